FILE: rtl/fme_pkg.sv
`timescale 1ns / 1ps
package fme_pkg;
	localparam int MAX_ELEMENTS = 64;
	localparam int COUNT_BITS = 20;
	localparam int IDX_BITS = $clog2(MAX_ELEMENTS);
	localparam int LEN_BITS = IDX_BITS + 1;
	localparam int VAL_BITS = 24;
	localparam int SUM_BITS = 44;
	localparam int DIV_BITS = SUM_BITS + 1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_RESET = 2'd1,
		OP_PRIOR = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_ADAPT = 2'd0,
		MODE_STATIC = 2'd1,
		MODE_FIXED = 2'd2,
		MODE_OTHER = 2'd3
	} mode_t;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_PERSIST = 2'd1;
	localparam logic [1:0] REG_POLE = 2'd2;
	localparam logic [1:0] REG_ELEMS = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MUL1,
		ST_MUL2,
		ST_CLR,
		ST_DREAD,
		ST_DLOAD,
		ST_DIV,
		ST_DEMIT,
		ST_OUT
	} state_t;

	function automatic logic signed [VAL_BITS-1:0] sat24(input logic signed [DIV_BITS:0] v);
		logic signed [DIV_BITS:0] hi;
		logic signed [DIV_BITS:0] lo;
		hi = (DIV_BITS+1)'(8388607);
		lo = -(DIV_BITS+1)'(8388608);
		if (v > hi) return VAL_BITS'(8388607);
		if (v < lo) return VAL_BITS'(-8388608);
		return v[VAL_BITS-1:0];
	endfunction
endpackage

FILE: rtl/feature_mean_estimator_unit.sv
`timescale 1ns / 1ps
// feature mean estimator
// input channel: in_valid / in_stall with opcode, element_index, sample_value, frame_end,
// stream_end. output channel: out_valid / out_stall with out_index, mean_value, last.
// configuration: cfg_we, cfg_index, cfg_data, written only when idle (a user rule, not enforced).
// one request at a time: in_stall is high while a request runs and until all its results
// are taken (not for a prior load, a persisting reset or an ignored sample). a prior load is
// written while idle; a sample is read, executed and output (with two multiply states once
// adaptive means are valid; a static sample that only accumulates gives no output); the
// multiply is two 24x18 signed products in sequence. a reset event, unless adaptive with
// persist, copies the prior into the mean and sum stores, all 64 entries, one entry a cycle.
// the static end-of-stream divide runs each element through the shared restoring divider
// (skipped when no frame was counted), then emits that element, n times. after reset
// all stores are undefined but a reset clearing pass writes zero to every entry before
// the first request is taken. when the receiver stalls the result holds in the output
// register and the block waits; nothing is lost.
module feature_mean_estimator_unit
	import fme_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] opcode,
	input logic [5:0] element_index,
	input logic signed [23:0] sample_value,
	input logic frame_end,
	input logic stream_end,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] out_index,
	output logic signed [23:0] mean_value,
	output logic last,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	state_t state_q, state_d;
	logic [1:0] mode_q;
	logic persist_q;
	logic [15:0] pole_q;
	logic [6:0] elems_q;
	logic [COUNT_BITS-1:0] fcount_q;
	logic valid_q;
	logic init_q;

	opcode_t op_q;
	logic [IDX_BITS-1:0] idx_q;
	logic signed [VAL_BITS-1:0] x_q;
	logic fend_q, send_q;
	logic [LEN_BITS-1:0] ptr_q;
	logic signed [41:0] acc_q;
	logic signed [41:0] prod;
	logic [DIV_BITS-1:0] s_mag;
	logic neg_q;
	logic signed [SUM_BITS-1:0] s_sum_q;

	logic [IDX_BITS-1:0] n_last;
	logic [LEN_BITS-1:0] n_len;

	logic m_we, p_we, s_we;
	logic [IDX_BITS-1:0] waddr, raddr;
	logic [VAL_BITS-1:0] m_wd, p_wd, m_rd, p_rd;
	logic [SUM_BITS-1:0] s_wd, s_rd;

	logic div_start;
	logic div_busy;
	logic [DIV_BITS-1:0] quo;

	fme_ram #(.WIDTH(VAL_BITS), .DEPTH(MAX_ELEMENTS)) u_mean (
		.clk, .we(m_we), .waddr, .wdata(m_wd), .raddr, .rdata(m_rd));
	fme_ram #(.WIDTH(VAL_BITS), .DEPTH(MAX_ELEMENTS)) u_prior (
		.clk, .we(p_we), .waddr, .wdata(p_wd), .raddr, .rdata(p_rd));
	fme_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_ELEMENTS)) u_sum (
		.clk, .we(s_we), .waddr, .wdata(s_wd), .raddr, .rdata(s_rd));

	// magnitude of the sum straight from the read port, loaded as the divide starts
	assign s_mag = s_rd[SUM_BITS-1] ? DIV_BITS'(-$signed({s_rd[SUM_BITS-1], s_rd}))
		: DIV_BITS'(s_rd);

	fme_div u_div (
		.clk, .arst_n, .start(div_start),
		.dividend(s_mag + DIV_BITS'(fcount_q >> 1)),
		.divisor(fcount_q), .busy(div_busy), .quotient(quo));

	always_comb begin
		if (elems_q == '0) n_len = LEN_BITS'(1);
		else if (elems_q > 7'(MAX_ELEMENTS)) n_len = LEN_BITS'(MAX_ELEMENTS);
		else n_len = LEN_BITS'(elems_q);
		n_last = IDX_BITS'(n_len - 1'b1);
	end

	// shared multiplier: pole*mean first, then (65536-pole)*x
	logic signed [23:0] mop;
	logic signed [17:0] wop;
	assign mop = (state_q == ST_MUL1) ? $signed(m_rd) : x_q;
	assign wop = (state_q == ST_MUL1) ? $signed({2'b00, pole_q})
		: $signed(18'(17'h10000 - 17'(pole_q)));
	assign prod = 42'(mop * wop);

	logic signed [SUM_BITS:0] s_add;
	logic signed [SUM_BITS-1:0] s_sat;
	assign s_add = $signed(s_rd) + (SUM_BITS+1)'(x_q);
	always_comb begin
		if (s_add[SUM_BITS] != s_add[SUM_BITS-1])
			s_sat = s_add[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
		else
			s_sat = s_add[SUM_BITS-1:0];
	end

	logic signed [41:0] acc_r;
	assign acc_r = acc_q + prod + 42'(32768);
	logic signed [DIV_BITS:0] qs;
	assign qs = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || !init_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!init_q) state_d = ST_CLR;
				else if (accept) begin
					if (opcode == OP_PRIOR) state_d = ST_IDLE;
					else if (opcode == OP_RESET)
						state_d = (mode_q == MODE_ADAPT && persist_q) ? ST_IDLE : ST_CLR;
					else if (opcode == OP_SAMPLE && 7'(element_index) < 7'(n_len))
						state_d = ST_READ;
				end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				if (mode_q == MODE_ADAPT) state_d = valid_q ? ST_MUL1 : ST_OUT;
				else if (mode_q == MODE_STATIC && !valid_q)
					state_d = send_q ? ST_DREAD : ST_IDLE;
				else state_d = ST_OUT;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_OUT;
			ST_CLR: if (ptr_q == LEN_BITS'(MAX_ELEMENTS - 1)) state_d = ST_IDLE;
			ST_DREAD: state_d = ST_DLOAD;
			ST_DLOAD: state_d = (fcount_q == '0) ? ST_DEMIT : ST_DIV;
			ST_DIV: if (!div_busy && !div_start) state_d = ST_DEMIT;
			ST_DEMIT: state_d = ST_OUT;
			ST_OUT: if (!out_stall)
				state_d = (op_q == OP_SAMPLE && mode_q == MODE_STATIC && !valid_q
					&& IDX_BITS'(ptr_q) != n_last) ? ST_DREAD : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic static_div;
	assign static_div = (mode_q == MODE_STATIC) && !valid_q;

	// clear pass reads prior ahead of the write, so sweep with a lagging pointer
	logic [IDX_BITS-1:0] clr_rd;
	always_comb clr_rd = IDX_BITS'(ptr_q + 1'b1);

	always_comb begin
		m_we = 1'b0;
		p_we = 1'b0;
		s_we = 1'b0;
		m_wd = '0;
		p_wd = x_q;
		s_wd = '0;
		waddr = idx_q;
		raddr = (state_q == ST_IDLE) ? element_index : idx_q;
		div_start = (state_q == ST_DLOAD) && (fcount_q != '0);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_PRIOR) begin
					p_we = 1'b1;
					waddr = element_index;
					p_wd = sample_value;
				end else if (accept && opcode == OP_RESET) begin
					raddr = '0;
				end
			end
			ST_EXEC: begin
				if (mode_q == MODE_ADAPT && !valid_q) begin
					m_we = 1'b1;
					m_wd = VAL_BITS'(x_q >>> 1);
				end else if (static_div) begin
					s_we = 1'b1;
					s_wd = s_sat;
				end
			end
			ST_MUL2: begin
				m_we = 1'b1;
				m_wd = acc_r[39:16];
			end
			ST_CLR: begin
				waddr = IDX_BITS'(ptr_q);
				raddr = clr_rd;
				m_we = 1'b1;
				s_we = 1'b1;
				m_wd = init_q ? p_rd : '0;
				s_wd = init_q ? SUM_BITS'($signed(p_rd)) : '0;
				p_we = !init_q;
				p_wd = '0;
			end
			ST_DREAD: raddr = IDX_BITS'(ptr_q);
			ST_DEMIT: begin
				waddr = IDX_BITS'(ptr_q);
				m_we = 1'b1;
				m_wd = (fcount_q == '0) ? sat24((DIV_BITS+1)'(s_sum_q)) : sat24(qs);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 2'(MODE_ADAPT);
			persist_q <= 1'b0;
			pole_q <= 16'd64225;
			elems_q <= 7'd13;
			fcount_q <= '0;
			valid_q <= 1'b0;
			init_q <= 1'b0;
			ptr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: mode_q <= cfg_data[1:0];
					REG_PERSIST: persist_q <= cfg_data[0];
					REG_POLE: pole_q <= cfg_data;
					REG_ELEMS: elems_q <= cfg_data[6:0];
				endcase
			end
			if (state_q == ST_CLR) begin
				ptr_q <= ptr_q + 1'b1;
				if (state_d == ST_IDLE) begin
					init_q <= 1'b1;
					ptr_q <= '0;
				end
			end
			if (state_q == ST_IDLE && accept && opcode == OP_RESET
				&& !(mode_q == MODE_ADAPT && persist_q)) begin
				fcount_q <= '0;
				if (mode_q == MODE_ADAPT || mode_q == MODE_STATIC) valid_q <= 1'b0;
				ptr_q <= '0;
			end
			if (state_q == ST_EXEC) begin
				if (mode_q == MODE_ADAPT && fend_q) valid_q <= 1'b1;
				if (static_div) begin
					if ((fend_q || send_q) && fcount_q != '1) fcount_q <= fcount_q + 1'b1;
					ptr_q <= '0;
				end
			end
			if (state_d == ST_OUT && state_q != ST_OUT) out_valid <= 1'b1;
			if (state_q == ST_OUT && !out_stall) begin
				out_valid <= 1'b0;
				if (state_d == ST_DREAD) ptr_q <= ptr_q + 1'b1;
				else if (op_q == OP_SAMPLE && static_div) begin
					valid_q <= 1'b1;
					ptr_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode_t'(opcode);
			idx_q <= element_index;
			x_q <= sample_value;
			fend_q <= frame_end;
			send_q <= stream_end;
		end
		if (state_q == ST_MUL1) acc_q <= prod;
		if (state_q == ST_DLOAD) begin
			s_sum_q <= $signed(s_rd);
			neg_q <= s_rd[SUM_BITS-1];
		end
		unique case (state_q)
			ST_EXEC: begin
				out_index <= idx_q;
				last <= 1'b1;
				if (mode_q == MODE_ADAPT) mean_value <= x_q >>> 1;
				else if (mode_q == MODE_STATIC) mean_value <= m_rd;
				else mean_value <= p_rd;
			end
			ST_MUL2: mean_value <= acc_r[39:16];
			ST_DEMIT: begin
				out_index <= IDX_BITS'(ptr_q);
				last <= (IDX_BITS'(ptr_q) == n_last);
				mean_value <= m_wd;
			end
			default: ;
		endcase
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mean_value) && $stable(out_index)))
		else $error("result changed under stall");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_OUT)) else $error("result outside output state");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (fcount_q != '0)) else $error("divide by zero count");
endmodule

FILE: rtl/fme_ram.sv
`timescale 1ns / 1ps
module fme_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/fme_div.sv
`timescale 1ns / 1ps
module fme_div
	import fme_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_BITS-1:0] dividend,
	input logic [COUNT_BITS-1:0] divisor,
	output logic busy,
	output logic [DIV_BITS-1:0] quotient
);
	// restoring divide, one quotient bit a cycle
	localparam int CNT_BITS = $clog2(DIV_BITS + 1);
	logic [DIV_BITS-1:0] q_q;
	logic [COUNT_BITS:0] r_q;
	logic [COUNT_BITS-1:0] d_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS+1:0] trial;

	assign trial = {r_q, q_q[DIV_BITS-1]} - {1'b0, 1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(DIV_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[COUNT_BITS+1]) begin
				r_q <= trial[COUNT_BITS:0];
				q_q <= {q_q[DIV_BITS-2:0], 1'b1};
			end else begin
				r_q <= {r_q[COUNT_BITS-1:0], q_q[DIV_BITS-1]};
				q_q <= {q_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = q_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy)
		else $error("divide started while busy");
	a_load: assert property (@(posedge clk) disable iff (!arst_n) start |=> busy)
		else $error("divide not running after start");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !start) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("divide counter skipped");
endmodule

FILE: test/tb_feature_mean_estimator_unit.sv
`timescale 1ns / 1ps
module tb_feature_mean_estimator_unit
	import fme_pkg::*;
();

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] opcode;
	logic [5:0] element_index;
	logic signed [23:0] sample_value;
	logic frame_end;
	logic stream_end;
	logic out_valid;
	logic out_stall;
	logic [5:0] out_index;
	logic signed [23:0] mean_value;
	logic last;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	feature_mean_estimator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .element_index(element_index), .sample_value(sample_value),
		.frame_end(frame_end), .stream_end(stream_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_index(out_index), .mean_value(mean_value), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct packed {
		logic [5:0] idx;
		logic signed [23:0] val;
		logic lst;
	} mean_result_t;

	mean_result_t pending_means[$];
	int error_count = 0;
	bit quiet_phase = 0;

	// shadow of the block
	logic [1:0] cur_mode;
	logic cur_persist;
	logic [15:0] cur_pole;
	logic [6:0] cur_elems;
	logic signed [23:0] mean_mem[64];
	logic signed [23:0] prior_mem[64];
	logic signed [43:0] sum_mem[64];
	logic [19:0] frames_seen;
	bit means_ready;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int vec_len();
		int e;
		e = cur_elems;
		if (e < 1) e = 1;
		if (e > 64) e = 64;
		return e;
	endfunction

	function automatic logic signed [23:0] clip24(longint v);
		if (v > 64'sd8388607) return 24'sd8388607;
		if (v < -64'sd8388608) return -24'sd8388608;
		return v[23:0];
	endfunction

	function automatic longint shr_floor(longint a, int s);
		return a >>> s;
	endfunction

	task automatic predict_means(logic [1:0] op, logic [5:0] idx, logic signed [23:0] x,
			logic fe, logic se);
		int n;
		longint acc;
		longint s;
		longint mag;
		longint q;
		mean_result_t r;
		n = vec_len();
		if (op == OP_PRIOR) begin
			prior_mem[idx] = x;
			return;
		end
		if (op == OP_RESET) begin
			if (!(cur_mode == MODE_ADAPT && cur_persist)) begin
				for (int i = 0; i < 64; i++) begin
					mean_mem[i] = prior_mem[i];
					sum_mem[i] = prior_mem[i];
				end
				frames_seen = 0;
				if (cur_mode == MODE_ADAPT || cur_mode == MODE_STATIC) means_ready = 0;
			end
			return;
		end
		if (op != OP_SAMPLE || idx >= n) return;
		if (cur_mode == MODE_ADAPT) begin
			if (means_ready) begin
				acc = longint'(cur_pole) * longint'(mean_mem[idx])
					+ (65536 - longint'(cur_pole)) * longint'(x);
				mean_mem[idx] = clip24(shr_floor(acc + 32768, 16));
			end else begin
				mean_mem[idx] = x >>> 1;
			end
			if (fe) means_ready = 1;
			r = '{idx, mean_mem[idx], 1'b1};
			pending_means.push_back(r);
		end else if (cur_mode == MODE_STATIC) begin
			if (means_ready) begin
				r = '{idx, mean_mem[idx], 1'b1};
				pending_means.push_back(r);
				return;
			end
			s = longint'(sum_mem[idx]) + longint'(x);
			if (s > (64'sd1 <<< 43) - 1) s = (64'sd1 <<< 43) - 1;
			if (s < -(64'sd1 <<< 43)) s = -(64'sd1 <<< 43);
			sum_mem[idx] = s;
			if ((fe || se) && frames_seen != 20'hFFFFF) frames_seen++;
			if (!se) return;
			for (int i = 0; i < n; i++) begin
				if (frames_seen == 0) begin
					mean_mem[i] = clip24(sum_mem[i]);
				end else begin
					mag = sum_mem[i] < 0 ? -longint'(sum_mem[i]) : longint'(sum_mem[i]);
					q = (mag + frames_seen / 2) / frames_seen;
					mean_mem[i] = clip24(sum_mem[i] < 0 ? -q : q);
				end
				r = '{i[5:0], mean_mem[i], (i == n - 1)};
				pending_means.push_back(r);
			end
			means_ready = 1;
		end else begin
			r = '{idx, prior_mem[idx], 1'b1};
			pending_means.push_back(r);
		end
	endtask

	// random receiver stalls in bursts
	initial begin
		int k;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				k = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (k) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		mean_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_means.size() == 0) begin
				$error("unexpected result index %0d value %0d", out_index, mean_value);
				error_count++;
			end else begin
				e = pending_means.pop_front();
				if (out_index !== e.idx) begin
					$error("out_index expected %0d actual %0d", e.idx, out_index);
					error_count++;
				end
				if (mean_value !== e.val) begin
					$error("mean_value expected %0d actual %0d", e.val, mean_value);
					error_count++;
				end
				if (last !== e.lst) begin
					$error("last expected %0d actual %0d", e.lst, last);
					error_count++;
				end
			end
		end
	end

	// valid stays high between back-to-back requests; a gap or a drain drops it
	task automatic send_request(logic [1:0] op, logic [5:0] idx, logic signed [23:0] x,
			logic fe, logic se);
		int k;
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			k = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (k) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		element_index <= idx;
		sample_value <= x;
		frame_end <= fe;
		stream_end <= se;
		do @(posedge clk); while (in_stall);
		predict_means(op, idx, x, fe, se);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(negedge clk);
		// a reset sweep or a silent request may still be running
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] ri, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		@(negedge clk);
		case (ri)
			REG_MODE: cur_mode = v[1:0];
			REG_PERSIST: cur_persist = v[0];
			REG_POLE: cur_pole = v;
			default: cur_elems = v[6:0];
		endcase
	endtask

	task automatic setup(logic [1:0] m, logic p, logic [15:0] pl, logic [6:0] n);
		drain_results();
		write_reg(REG_MODE, 16'(m));
		write_reg(REG_PERSIST, 16'(p));
		write_reg(REG_POLE, pl);
		write_reg(REG_ELEMS, 16'(n));
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_frame(int n, bit se);
		for (int i = 0; i < n; i++)
			send_request(OP_SAMPLE, 6'(i), rand_value(), i == n - 1, se && i == n - 1);
	endtask

	task automatic test_directed();
		for (int i = 0; i < 4; i++) send_request(OP_PRIOR, 6'(i), rand_value(), 0, 0);
		send_request(OP_PRIOR, 63, 24'sh7FFFFF, 1, 1);
		setup(MODE_ADAPT, 0, 16'd65535, 7'd3);
		send_request(OP_RESET, 0, 0, 0, 0);
		send_frame(3, 0);
		send_request(OP_SAMPLE, 0, 24'sh7FFFFF, 0, 1);
		send_request(OP_SAMPLE, 1, 24'sh800000, 1, 0);
		send_request(OP_SAMPLE, 5, 24'sh123456, 0, 0);
		send_request(OP_NONE, 0, 24'sh1, 1, 1);
		setup(MODE_STATIC, 1, 16'd1, 7'd0);
		send_request(OP_RESET, 0, 0, 0, 0);
		send_request(OP_SAMPLE, 0, 24'sh800000, 0, 1);
		send_request(OP_SAMPLE, 0, 24'sh7FFFFF, 1, 1);
		setup(MODE_FIXED, 0, 16'd1, 7'd127);
		send_request(OP_SAMPLE, 63, 0, 0, 0);
		send_request(OP_SAMPLE, 0, 0, 0, 0);
		setup(MODE_OTHER, 1, 16'd1, 7'd64);
		send_request(OP_SAMPLE, 2, 0, 0, 0);
		send_request(OP_RESET, 0, 0, 0, 0);
	endtask

	task automatic test_adaptive();
		int n;
		n = $urandom_range(1, 8);
		setup(MODE_ADAPT, 1'($urandom_range(0, 1)), 16'($urandom_range(1, 65535)), 7'(n));
		send_request(OP_RESET, 0, 0, 0, 0);
		repeat ($urandom_range(2, 5)) send_frame(n, 1'($urandom_range(0, 1)));
		send_request(OP_RESET, 0, 0, 0, 0);
		send_frame(n, 0);
	endtask

	task automatic test_static();
		int n;
		n = $urandom_range(1, 6);
		setup(MODE_STATIC, 1'($urandom_range(0, 1)), 16'($urandom), 7'(n));
		for (int i = 0; i < n; i++) send_request(OP_PRIOR, 6'(i), rand_value(), 0, 0);
		send_request(OP_RESET, 0, 0, 0, 0);
		repeat ($urandom_range(1, 4)) send_frame(n, 0);
		send_frame(n, 1);
		send_request(OP_SAMPLE, 6'($urandom_range(0, n - 1)), rand_value(), 1, 1);
	endtask

	task automatic test_noise();
		repeat (20)
			send_request(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), rand_value(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_SAMPLE;
		element_index = '0;
		sample_value = '0;
		frame_end = 1'b0;
		stream_end = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		cur_mode = MODE_ADAPT;
		cur_persist = 0;
		cur_pole = 16'd64225;
		cur_elems = 7'd13;
		for (int i = 0; i < 64; i++) begin
			mean_mem[i] = 0;
			prior_mem[i] = 0;
			sum_mem[i] = 0;
		end
		frames_seen = 0;
		means_ready = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		repeat (6) test_adaptive();
		repeat (6) test_static();
		setup(MODE_FIXED, 0, 16'd100, 7'd64);
		test_noise();
		setup(MODE_ADAPT, 0, 16'd40000, 7'd64);
		test_noise();
		quiet_phase = 1;
		test_adaptive();
		test_static();
		drain_results();
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
